>>> rtl/pidsteer_pkg.sv
// Shared constants for the steering torque PID controller with feedforward.
package pidsteer_pkg;

	// Fixed field widths
	localparam int ANGLE_W  = 19;
	localparam int SPEED_W  = 14;
	localparam int TORQUE_W = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;

	// Default fraction bits of the angle format
	localparam int ANGLE_FRAC_BITS_DEF = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_COEF  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_COEF  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_TORQUE = 3'd7;

	// Register reset values
	localparam logic [31:0] PROP_GAIN_RST   = 32'd65536;
	localparam logic [31:0] INTEG_GAIN_RST  = 32'd655;
	localparam logic [31:0] DERIV_GAIN_RST  = 32'd0;
	localparam logic [30:0] INTEG_LIMIT_RST = 31'd655360;
	localparam logic [23:0] SPEED_COEF_RST  = 24'd141734;
	localparam logic [31:0] ANGLE_COEF_RST  = 32'd91750;
	localparam logic [24:0] MAX_SPEED_RST   = 25'd11796480;
	localparam logic [31:0] BASE_TORQUE_RST = 32'd0;

	// m/s to km/h in Q16.16: times 4608, then divide by 5 via reciprocal
	localparam logic [12:0] KMH_SCALE  = 13'd4608;
	localparam logic [32:0] DIV5_RECIP = 33'h0_CCCC_CCCD;

	// Divide-by-three on the scaled cubic term by reciprocal multiply:
	// (2^35+1)/3 is 2^33 plus this low part, and the quotient is taken at bit 35
	localparam int          DIV_W         = 34;
	localparam logic [31:0] DIV3_RECIP_LO = 32'hAAAA_AAAB;

endpackage

>>> rtl/pid_steering_torque_with_feedforward_top.sv
// Steering torque controller: PID plus speed and angle feedforward over one shared multiplier.
// With eight angle fraction bits, the 22-step bit-serial square root, started at the transfer,
// sets when out_valid rises; the twelve-step multiplier sequence runs alongside it. A new item
// is taken only after the last result is registered; a result still held by out_stall delays that.
// A clear item gives no result and does not hold off the next item.
// Reset: arst_n clears the sequencer, integrator, last error and output valid, and loads defaults.
module pid_steering_torque_with_feedforward_top #(
	parameter int ANGLE_FRAC_BITS = pidsteer_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [pidsteer_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pidsteer_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   req_type,
	input  logic signed [pidsteer_pkg::ANGLE_W-1:0] tgt_angle,
	input  logic signed [pidsteer_pkg::ANGLE_W-1:0] meas_angle,
	input  logic [pidsteer_pkg::SPEED_W-1:0]       speed,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [pidsteer_pkg::TORQUE_W-1:0] torque
);
	import pidsteer_pkg::*;

	localparam int F      = ANGLE_FRAC_BITS;
	localparam int SHIFT  = 32 - F;
	localparam int RW     = ANGLE_W + SHIFT;
	localparam int RW_E   = RW + (RW % 2);
	localparam int RN     = RW_E / 2;
	localparam int SQ_CW  = $clog2(RN + 1);
	localparam logic [ANGLE_W-1:0] BAND = ANGLE_W'(2 << F);

	typedef enum logic [3:0] {
		ST_IDLE, ST_P, ST_I, ST_D, ST_V, ST_VV, ST_KV, ST_X, ST_DLOAD, ST_DIV, ST_DQ,
		ST_SH, ST_SHU, ST_YS, ST_YSU, ST_FIN
	} state_t;

	state_t state_q;

	// Configuration registers
	logic signed [31:0] prop_gain_q, integ_gain_q, deriv_gain_q, angle_coef_q, base_torque_q;
	logic [30:0] integ_limit_q;
	logic [23:0] speed_coef_q;
	logic [24:0] max_speed_q;

	// Item and controller state
	logic signed [ANGLE_W-1:0] t_q;
	logic [SPEED_W-1:0]        speed_q;
	logic signed [19:0]        err_q, last_err_q;
	logic signed [31:0]        integ_q;
	logic signed [63:0]        acc_q;
	logic signed [27:0]        d6_q;
	logic                      x_neg_q;
	logic [35:0]               yabs_q;
	logic                      out_valid_q;
	logic signed [31:0]        torque_q;

	// Shared multiplier
	logic signed [35:0] op_a;
	logic signed [32:0] op_b;
	logic signed [68:0] prod_q;

	// Divide-by-three
	logic [DIV_W-1:0]  dv_y_q, dv_quo_q;
	logic [67:0]       dv_sum;

	// Serial square root
	logic [RW_E-1:0]  sq_rad_q;
	logic [RN+1:0]    sq_rem_q;
	logic [RN-1:0]    sq_root_q;
	logic [SQ_CW-1:0] sq_cnt_q;
	logic [RN+3:0]    sq_rem2, sq_trial;

	// Combinational helpers
	logic               in_xfer, out_xfer;
	logic [ANGLE_W-1:0] tabs_in, tabs;
	logic               t_pos, t_neg, in_band;
	logic signed [20:0] diff;
	logic signed [68:0] asr_w;
	logic signed [63:0] inew, lim64;
	logic [68:0]        pmag;
	logic signed [35:0] polyv, yv;
	logic [35:0]        yabs_w;
	logic signed [63:0] sh_mag, shaped, ys_mag, ys;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign torque    = torque_q;

	// Operand select and derived values
	always_comb begin
		tabs_in = tgt_angle[ANGLE_W-1] ? ANGLE_W'(-tgt_angle) : ANGLE_W'(tgt_angle);
		tabs    = t_q[ANGLE_W-1] ? ANGLE_W'(-t_q) : ANGLE_W'(t_q);
		t_neg   = t_q[ANGLE_W-1];
		t_pos   = !t_q[ANGLE_W-1] && (t_q != '0);
		in_band = (tabs <= BAND);
		diff    = 21'(err_q) - 21'(last_err_q);
		asr_w   = prod_q >>> F;
		inew    = 64'(integ_q) + 64'(asr_w);
		lim64   = 64'({1'b0, integ_limit_q});
		pmag    = prod_q[68] ? 69'(-prod_q) : 69'(prod_q);
		dv_sum  = {1'b0, dv_y_q, 33'd0} + {2'b00, prod_q[65:0]};
		polyv   = x_neg_q ? 36'(-signed'({2'b00, dv_quo_q})) : signed'({2'b00, dv_quo_q});
		yv      = 36'(base_torque_q) - polyv;
		yabs_w  = yv[35] ? 36'(-yv) : 36'(yv);
		sh_mag  = in_band ? 64'(prod_q >>> (F + 1)) : 64'({28'd0, yabs_q});
		shaped  = t_neg ? -sh_mag : (t_pos ? sh_mag : 64'sd0);
		ys_mag  = 64'(pmag >> 16);
		ys      = t_neg ? -ys_mag : (t_pos ? ys_mag : 64'sd0);
		sq_rem2  = {sq_rem_q, sq_rad_q[RW_E-1 -: 2]};
		sq_trial = {2'b00, sq_root_q, 2'b01};

		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_P: begin
				op_a = 36'(err_q);
				op_b = 33'(prop_gain_q);
			end
			ST_I: begin
				op_a = 36'(err_q);
				op_b = 33'(integ_gain_q);
			end
			ST_D: begin
				op_a = 36'(diff);
				op_b = 33'(deriv_gain_q);
			end
			ST_V: begin
				op_a = signed'(36'(speed_q * KMH_SCALE));
				op_b = signed'(DIV5_RECIP);
			end
			ST_VV: begin
				op_a = signed'({12'd0, prod_q[57:34]});
				op_b = signed'({9'd0, prod_q[57:34]});
			end
			ST_KV: begin
				op_a = signed'({12'd0, speed_coef_q});
				op_b = signed'({1'b0, prod_q[47:16]});
			end
			ST_X: begin
				op_a = signed'({4'd0, prod_q[55:24]});
				op_b = 33'(d6_q);
			end
			ST_DIV: begin
				op_a = signed'({2'b00, dv_y_q});
				op_b = signed'({1'b0, DIV3_RECIP_LO});
			end
			ST_SH: begin
				op_a = signed'(yabs_w);
				op_b = signed'(33'(tabs));
			end
			ST_YS, ST_YSU: begin
				op_a = 36'(angle_coef_q);
				op_b = signed'(33'(sq_root_q));
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Register the product of the shared multiplier
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= PROP_GAIN_RST;
			integ_gain_q  <= INTEG_GAIN_RST;
			deriv_gain_q  <= DERIV_GAIN_RST;
			integ_limit_q <= INTEG_LIMIT_RST;
			speed_coef_q  <= SPEED_COEF_RST;
			angle_coef_q  <= ANGLE_COEF_RST;
			max_speed_q   <= MAX_SPEED_RST;
			base_torque_q <= BASE_TORQUE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data;
				REG_INTEG_GAIN:  integ_gain_q  <= cfg_data;
				REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data;
				REG_INTEG_LIMIT: integ_limit_q <= cfg_data[30:0];
				REG_SPEED_COEF:  speed_coef_q  <= cfg_data[23:0];
				REG_ANGLE_COEF:  angle_coef_q  <= cfg_data;
				REG_MAX_SPEED:   max_speed_q   <= cfg_data[24:0];
				REG_BASE_TORQUE: base_torque_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step the square root, one result bit per cycle, started on the transfer of a non-clear item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
		end else if (in_xfer && !req_type) begin
			sq_cnt_q <= SQ_CW'(RN);
		end else if (sq_cnt_q != '0) begin
			sq_cnt_q <= sq_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && !req_type) begin
			sq_rad_q  <= RW_E'({tabs_in, {SHIFT{1'b0}}});
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (sq_cnt_q != '0) begin
			sq_rad_q <= {sq_rad_q[RW_E-3:0], 2'b00};
			if (sq_rem2 >= sq_trial) begin
				sq_rem_q  <= (RN+2)'(sq_rem2 - sq_trial);
				sq_root_q <= {sq_root_q[RN-2:0], 1'b1};
			end else begin
				sq_rem_q  <= sq_rem2[RN+1:0];
				sq_root_q <= {sq_root_q[RN-2:0], 1'b0};
			end
		end
	end

	// Sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			integ_q     <= '0;
			last_err_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_xfer && state_q != ST_FIN)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (req_type) begin
							integ_q <= '0;
						end else begin
							t_q     <= tgt_angle;
							speed_q <= speed;
							err_q   <= 20'(tgt_angle) - 20'(meas_angle);
							state_q <= ST_P;
						end
					end
				end
				ST_P: state_q <= ST_I;
				ST_I: begin
					acc_q   <= 64'(asr_w);
					state_q <= ST_D;
				end
				ST_D: begin
					if (inew > lim64)
						integ_q <= 32'(lim64);
					else if (inew < -lim64)
						integ_q <= 32'(-lim64);
					else
						integ_q <= 32'(inew);
					acc_q <= acc_q + ((inew > lim64) ? lim64 :
						((inew < -lim64) ? -lim64 : inew));
					state_q <= ST_V;
				end
				ST_V: begin
					acc_q      <= acc_q + 64'(asr_w);
					last_err_q <= err_q;
					state_q    <= ST_VV;
				end
				ST_VV: begin
					d6_q    <= signed'(28'({prod_q[57:34], 1'b0})) -
						signed'(28'(max_speed_q * 2'd3));
					state_q <= ST_KV;
				end
				ST_KV: state_q <= ST_X;
				ST_X:  state_q <= ST_DLOAD;
				ST_DLOAD: begin
					x_neg_q <= prod_q[68];
					dv_y_q  <= pmag[58:25];
					state_q <= ST_DIV;
				end
				ST_DIV: state_q <= ST_DQ;
				// Take the quotient by three from the reciprocal product
				ST_DQ: begin
					dv_quo_q <= {1'b0, dv_sum[67:35]};
					state_q  <= ST_SH;
				end
				ST_SH: begin
					yabs_q  <= yabs_w;
					state_q <= ST_SHU;
				end
				ST_SHU: begin
					acc_q   <= acc_q + shaped;
					state_q <= ST_YS;
				end
				ST_YS: begin
					if (sq_cnt_q == '0)
						state_q <= ST_YSU;
				end
				ST_YSU: begin
					acc_q   <= acc_q + ys;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						if (acc_q > 64'sd2147483647)
							torque_q <= 32'sh7FFF_FFFF;
						else if (acc_q < -64'sd2147483648)
							torque_q <= 32'sh8000_0000;
						else
							torque_q <= 32'(acc_q);
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// A clear transfer zeroes the integrator
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && req_type |=> integ_q == '0)
		else $error("integrator not cleared");

	// The square root is finished before its product is used
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_YSU |-> sq_cnt_q == '0)
		else $error("square root used before done");

	// A result appears only from the final step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result outside final step");

	// A stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(torque_q))
		else $error("stalled result changed");
`endif

endmodule
